FILE: design/wqult_pkg.sv
// Package for the word query usage learning table.
// Holds table sizes, entry and configuration types, and request codes.
`timescale 1ns / 1ps
package wqult_pkg;
   localparam int ENTRIES = 256;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int COUNT_W = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   // request codes
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_RECORD = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_SCORE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_FREQ_CAP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_FREQ_STEP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_RECENCY_WINDOW = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_RECENCY_STEP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_FREQ_CAP = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_FREQ_STEP = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_PREFERRED_WINDOW = 3'd6;

   localparam logic [1:0] RANK_PREFERRED = 2'd2;
   localparam logic [1:0] RANK_NONE = 2'd0;

   typedef struct packed {
      logic               wv;
      logic [31:0]        wkey;
      logic [COUNT_W-1:0] wuses;
      logic [31:0]        wstamp;
      logic               qv;
      logic [31:0]        qkey;
      logic [31:0]        qword;
      logic [COUNT_W-1:0] quses;
      logic [31:0]        qstamp;
   } entry_type;

   typedef struct packed {
      logic [7:0]  word_freq_cap;
      logic [15:0] word_freq_step;
      logic [15:0] word_recency_window;
      logic [15:0] word_recency_step;
      logic [7:0]  query_freq_cap;
      logic [15:0] query_freq_step;
      logic [31:0] query_preferred_window;
   } cfg_type;
endpackage

FILE: design/wqult_cell.sv
// One ring cell: holds a word entry and a query entry, passes them on when shifting.
// Depends on wqult_pkg.
`timescale 1ns / 1ps
module wqult_cell
   import wqult_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type entry_in,
   output entry_type entry_out
);
   entry_type entry_ff;

   // take the neighbor's entry on shift; reset clears the whole entry
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
endmodule

FILE: design/wqult_ctrl.sv
// Head unit of the ring: sequences scan and write passes, updates entries, forms results.
// Depends on wqult_pkg.
`timescale 1ns / 1ps
module wqult_ctrl
   import wqult_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  func,
   input  logic [31:0] word_id,
   input  logic [31:0] qhash,
   input  cfg_type     cfg,
   input  entry_type   head,
   output entry_type   wback,
   output logic        shift,
   output logic        busy,
   output logic        rsp_valid,
   output logic        rsp_removed,
   output logic [7:0]  rsp_use_count,
   output logic [23:0] rsp_freq_bonus,
   output logic [31:0] rsp_recency_bonus,
   output logic [23:0] rsp_query_bonus,
   output logic [1:0]  rsp_preference_rank
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0] func_ff, func_in;
   logic [31:0] id_ff, id_in, hash_ff, hash_in, clock_ff, clock_in;
   logic w_hit_ff, w_hit_in, w_inv_ff, w_inv_in, q_sel_ff, q_sel_in;
   logic [IDX_W-1:0] w_hit_idx_ff, w_hit_idx_in, w_inv_idx_ff, w_inv_idx_in;
   logic [IDX_W-1:0] w_min_idx_ff, w_min_idx_in, q_sel_idx_ff, q_sel_idx_in;
   logic [IDX_W-1:0] q_min_idx_ff, q_min_idx_in;
   logic [31:0] w_min_stamp_ff, w_min_stamp_in, q_min_stamp_ff, q_min_stamp_in;
   logic s_wfound_ff, s_wfound_in, s_rec_ok_ff, s_rec_ok_in;
   logic s_qfound_ff, s_qfound_in, s_pref_ff, s_pref_in, hit_ff, hit_in;
   logic [7:0] s_uses_ff, s_uses_in, s_quses_ff, s_quses_in;
   logic [15:0] s_rec_diff_ff, s_rec_diff_in;
   logic rsp_valid_ff;
   logic rsp_removed_ff;
   logic [7:0] rsp_use_count_ff;
   logic [23:0] rsp_freq_ff, rsp_qbonus_ff;
   logic [31:0] rsp_rec_ff;
   logic [1:0] rsp_rank_ff;

   logic w_match, q_match, q_remove_match, last;
   logic [31:0] w_age, q_age;
   logic [IDX_W-1:0] w_target, q_target;
   logic q_restart;
   logic [7:0] w_cap_uses, q_cap_uses;

   assign w_match = head.wv && (head.wkey == id_ff);
   assign q_match = head.qv && (head.qkey == hash_ff) && (head.qword == id_ff);
   assign q_remove_match = head.qv && (head.qword == id_ff)
                           && ((hash_ff == 32'd0) || (head.qkey == hash_ff));
   assign w_age = clock_ff - head.wstamp;
   assign q_age = clock_ff - head.qstamp;
   assign last = (idx_ff == IDX_LAST);
   assign w_target = w_hit_ff ? w_hit_idx_ff : (w_inv_ff ? w_inv_idx_ff : w_min_idx_ff);
   assign q_target = q_sel_ff ? q_sel_idx_ff : q_min_idx_ff;
   assign q_restart = !head.qv || (head.qkey != hash_ff) || (head.qword != id_ff);

   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_WRITE);
   assign busy = (state_ff != ST_IDLE);

   // modify the entry leaving the head before it reenters the ring tail
   always_comb begin
      wback = head;
      if (state_ff == ST_SCAN && func_ff == FUNC_REMOVE) begin
         if (w_match) begin
            wback.wv = 1'b0;
            wback.wkey = 32'd0;
            wback.wuses = '0;
            wback.wstamp = 32'd0;
         end
         if (q_remove_match) begin
            wback.qv = 1'b0;
            wback.qkey = 32'd0;
            wback.qword = 32'd0;
            wback.quses = '0;
            wback.qstamp = 32'd0;
         end
      end else if (state_ff == ST_WRITE) begin
         if (idx_ff == w_target) begin
            wback.wv = 1'b1;
            wback.wkey = id_ff;
            wback.wstamp = clock_ff;
            if (!w_hit_ff) begin
               wback.wuses = 8'd1;
            end else if (head.wuses != COUNT_MAX) begin
               wback.wuses = head.wuses + 8'd1;
            end
         end
         if (hash_ff != 32'd0 && idx_ff == q_target) begin
            wback.qv = 1'b1;
            wback.qkey = hash_ff;
            wback.qword = id_ff;
            wback.qstamp = clock_ff;
            if (q_restart) begin
               wback.quses = 8'd1;
            end else if (head.quses != COUNT_MAX) begin
               wback.quses = head.quses + 8'd1;
            end
         end
      end
   end

   // sequence control and accumulate scan results
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      func_in = func_ff;
      id_in = id_ff;
      hash_in = hash_ff;
      clock_in = clock_ff;
      w_hit_in = w_hit_ff;
      w_hit_idx_in = w_hit_idx_ff;
      w_inv_in = w_inv_ff;
      w_inv_idx_in = w_inv_idx_ff;
      w_min_idx_in = w_min_idx_ff;
      w_min_stamp_in = w_min_stamp_ff;
      q_sel_in = q_sel_ff;
      q_sel_idx_in = q_sel_idx_ff;
      q_min_idx_in = q_min_idx_ff;
      q_min_stamp_in = q_min_stamp_ff;
      s_wfound_in = s_wfound_ff;
      s_uses_in = s_uses_ff;
      s_rec_ok_in = s_rec_ok_ff;
      s_rec_diff_in = s_rec_diff_ff;
      s_qfound_in = s_qfound_ff;
      s_quses_in = s_quses_ff;
      s_pref_in = s_pref_ff;
      hit_in = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = func;
               id_in = word_id;
               hash_in = qhash;
               idx_in = '0;
               w_hit_in = 1'b0;
               w_inv_in = 1'b0;
               q_sel_in = 1'b0;
               s_wfound_in = 1'b0;
               s_qfound_in = 1'b0;
               s_pref_in = 1'b0;
               hit_in = 1'b0;
               if (func == FUNC_TICK) begin
                  clock_in = clock_ff + 32'd1;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // word lookup, free slot and oldest entry
            if (w_match && !w_hit_ff) begin
               w_hit_in = 1'b1;
               w_hit_idx_in = idx_ff;
            end
            if (!head.wv && !w_inv_ff) begin
               w_inv_in = 1'b1;
               w_inv_idx_in = idx_ff;
            end
            if (idx_ff == '0 || (head.wv && head.wstamp < w_min_stamp_ff)) begin
               w_min_idx_in = idx_ff;
               w_min_stamp_in = head.wstamp;
            end
            // query slot and oldest query entry
            if ((!head.qv || head.qkey == hash_ff) && !q_sel_ff) begin
               q_sel_in = 1'b1;
               q_sel_idx_in = idx_ff;
            end
            if (idx_ff == '0 || (head.qv && head.qstamp < q_min_stamp_ff)) begin
               q_min_idx_in = idx_ff;
               q_min_stamp_in = head.qstamp;
            end
            // score capture: counts from the first matching entries, preference from any match
            if (w_match && !s_wfound_ff) begin
               s_wfound_in = 1'b1;
               s_uses_in = head.wuses;
               s_rec_ok_in = (w_age < {16'd0, cfg.word_recency_window});
               s_rec_diff_in = cfg.word_recency_window - w_age[15:0];
            end
            if (hash_ff != 32'd0 && q_match) begin
               if (!s_qfound_ff) begin
                  s_qfound_in = 1'b1;
                  s_quses_in = head.quses;
               end
               if (q_age <= cfg.query_preferred_window) begin
                  s_pref_in = 1'b1;
               end
            end
            if (w_match || q_remove_match) begin
               hit_in = 1'b1;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (last) begin
               state_in = (func_ff == FUNC_RECORD) ? ST_WRITE : ST_FIN;
            end
         end
         ST_WRITE: begin
            idx_in = idx_ff + IDX_W'(1);
            if (last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign w_cap_uses = (s_uses_ff < cfg.word_freq_cap) ? s_uses_ff : cfg.word_freq_cap;
   assign q_cap_uses = (s_quses_ff < cfg.query_freq_cap) ? s_quses_ff : cfg.query_freq_cap;

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clock_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clock_ff <= clock_in;
         rsp_valid_ff <= (state_ff == ST_FIN);
      end
   end

   // advance scan registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      func_ff <= func_in;
      id_ff <= id_in;
      hash_ff <= hash_in;
      w_hit_ff <= w_hit_in;
      w_hit_idx_ff <= w_hit_idx_in;
      w_inv_ff <= w_inv_in;
      w_inv_idx_ff <= w_inv_idx_in;
      w_min_idx_ff <= w_min_idx_in;
      w_min_stamp_ff <= w_min_stamp_in;
      q_sel_ff <= q_sel_in;
      q_sel_idx_ff <= q_sel_idx_in;
      q_min_idx_ff <= q_min_idx_in;
      q_min_stamp_ff <= q_min_stamp_in;
      s_wfound_ff <= s_wfound_in;
      s_uses_ff <= s_uses_in;
      s_rec_ok_ff <= s_rec_ok_in;
      s_rec_diff_ff <= s_rec_diff_in;
      s_qfound_ff <= s_qfound_in;
      s_quses_ff <= s_quses_in;
      s_pref_ff <= s_pref_in;
      hit_ff <= hit_in;
   end

   // form the result; fields that the request does not produce stay zero
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN) begin
         rsp_removed_ff <= (func_ff == FUNC_REMOVE) && hit_ff;
         rsp_use_count_ff <= '0;
         rsp_freq_ff <= '0;
         rsp_rec_ff <= '0;
         rsp_qbonus_ff <= '0;
         rsp_rank_ff <= RANK_NONE;
         if (func_ff == FUNC_SCORE) begin
            if (s_wfound_ff) begin
               rsp_use_count_ff <= s_uses_ff;
               rsp_freq_ff <= w_cap_uses * cfg.word_freq_step;
               if (s_rec_ok_ff) begin
                  rsp_rec_ff <= s_rec_diff_ff * cfg.word_recency_step;
               end
            end
            if (s_qfound_ff) begin
               rsp_qbonus_ff <= q_cap_uses * cfg.query_freq_step;
            end
            if (s_pref_ff) begin
               rsp_rank_ff <= RANK_PREFERRED;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_use_count = rsp_use_count_ff;
   assign rsp_freq_bonus = rsp_freq_ff;
   assign rsp_recency_bonus = rsp_rec_ff;
   assign rsp_query_bonus = rsp_qbonus_ff;
   assign rsp_preference_rank = rsp_rank_ff;
endmodule

FILE: design/word_query_usage_learning_table_core.sv
// Top level of the word query usage learning table: ring of entry cells, head unit, registers.
// Depends on wqult_pkg, wqult_cell and wqult_ctrl.
`timescale 1ns / 1ps
// A tick request goes from acceptance through ST_FIN to its registered result strobe;
// remove and score pass through ST_SCAN and record through ST_SCAN and ST_WRITE first.
// These passes are set by the ring of 256 cells, which rotates one entry past the single
// head unit per cycle: one full turn to scan, a second turn to write for record. Busy is
// high until the result strobe cycle; the next request may start in that cycle. The
// receiver cannot stall: each result is flagged by rsp_valid for one cycle only.
module word_query_usage_learning_table_core
   import wqult_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_func,
   input  logic [31:0]            req_word_id,
   input  logic [31:0]            req_qhash,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   output logic                   rsp_removed,
   output logic [7:0]             rsp_use_count,
   output logic [23:0]            rsp_freq_bonus,
   output logic [31:0]            rsp_recency_bonus,
   output logic [23:0]            rsp_query_bonus,
   output logic [1:0]             rsp_preference_rank
);
   cfg_type cfg_ff;
   entry_type ring [ENTRIES];
   entry_type head, wback;
   logic shift;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.word_freq_cap <= 8'd16;
         cfg_ff.word_freq_step <= 16'd8;
         cfg_ff.word_recency_window <= 16'd64;
         cfg_ff.word_recency_step <= 16'd4;
         cfg_ff.query_freq_cap <= 8'd16;
         cfg_ff.query_freq_step <= 16'd16;
         cfg_ff.query_preferred_window <= 32'd32;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WORD_FREQ_CAP: cfg_ff.word_freq_cap <= csr_data[7:0];
            CSR_WORD_FREQ_STEP: cfg_ff.word_freq_step <= csr_data[15:0];
            CSR_WORD_RECENCY_WINDOW: cfg_ff.word_recency_window <= csr_data[15:0];
            CSR_WORD_RECENCY_STEP: cfg_ff.word_recency_step <= csr_data[15:0];
            CSR_QUERY_FREQ_CAP: cfg_ff.query_freq_cap <= csr_data[7:0];
            CSR_QUERY_FREQ_STEP: cfg_ff.query_freq_step <= csr_data[15:0];
            CSR_QUERY_PREFERRED_WINDOW: cfg_ff.query_preferred_window <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ring of cells: each takes from its upper neighbor, the last from the head unit
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type cell_in;
      if (i == ENTRIES - 1) begin : g_tail
         assign cell_in = wback;
      end else begin : g_mid
         assign cell_in = ring[i+1];
      end
      wqult_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .entry_in  (cell_in),
         .entry_out (ring[i])
      );
   end

   assign head = ring[0];

   wqult_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .func                (req_func),
      .word_id             (req_word_id),
      .qhash               (req_qhash),
      .cfg                 (cfg_ff),
      .head                (head),
      .wback               (wback),
      .shift               (shift),
      .busy                (busy),
      .rsp_valid           (rsp_valid),
      .rsp_removed         (rsp_removed),
      .rsp_use_count       (rsp_use_count),
      .rsp_freq_bonus      (rsp_freq_bonus),
      .rsp_recency_bonus   (rsp_recency_bonus),
      .rsp_query_bonus     (rsp_query_bonus),
      .rsp_preference_rank (rsp_preference_rank)
   );
endmodule

FILE: verif/word_query_usage_learning_table_core_tb.sv
// Testbench for word_query_usage_learning_table_core: random and directed requests,
// checked against a scoreboard class holding its own copy of both tables.
// Depends on wqult_pkg and the design top level.
`timescale 1ns / 1ps

// Expected response of one request
typedef struct {
   logic        removed;
   logic [7:0]  use_count;
   logic [23:0] freq_bonus;
   logic [31:0] recency_bonus;
   logic [23:0] query_bonus;
   logic [1:0]  preference_rank;
} usage_resp_type;

class usage_scoreboard;
   // configuration copy
   logic [7:0]  wcap;
   logic [15:0] wstep;
   logic [15:0] rwin;
   logic [15:0] rstep;
   logic [7:0]  qcap;
   logic [15:0] qstep;
   logic [31:0] pwin;
   // table copy
   logic [31:0] clk_now;
   logic        wv[256];
   logic [31:0] wkey[256];
   logic [7:0]  wuses[256];
   logic [31:0] wstamp[256];
   logic        qv[256];
   logic [31:0] qkey[256];
   logic [31:0] qword[256];
   logic [7:0]  quses[256];
   logic [31:0] qstamp[256];
   usage_resp_type pending[$];
   int errors;

   function new();
      wcap = 16; wstep = 8; rwin = 64; rstep = 4;
      qcap = 16; qstep = 16; pwin = 32;
      clk_now = 0;
      errors = 0;
      for (int i = 0; i < 256; i++) begin
         wv[i] = 0; wkey[i] = 0; wuses[i] = 0; wstamp[i] = 0;
         qv[i] = 0; qkey[i] = 0; qword[i] = 0; quses[i] = 0; qstamp[i] = 0;
      end
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         wqult_pkg::CSR_WORD_FREQ_CAP: wcap = val[7:0];
         wqult_pkg::CSR_WORD_FREQ_STEP: wstep = val[15:0];
         wqult_pkg::CSR_WORD_RECENCY_WINDOW: rwin = val[15:0];
         wqult_pkg::CSR_WORD_RECENCY_STEP: rstep = val[15:0];
         wqult_pkg::CSR_QUERY_FREQ_CAP: qcap = val[7:0];
         wqult_pkg::CSR_QUERY_FREQ_STEP: qstep = val[15:0];
         wqult_pkg::CSR_QUERY_PREFERRED_WINDOW: pwin = val;
         default: ;
      endcase
   endfunction

   function int lookup_word(logic [31:0] id);
      for (int i = 0; i < 256; i++)
         if (wv[i] && wkey[i] == id) return i;
      return -1;
   endfunction

   // first free slot, else first oldest stamp
   function int pick_word_slot();
      int v;
      v = 0;
      for (int i = 0; i < 256; i++) begin
         if (!wv[i]) return i;
         if (wstamp[i] < wstamp[v]) v = i;
      end
      return v;
   endfunction

   function int pick_query_slot(logic [31:0] hash);
      int v;
      v = 0;
      for (int i = 0; i < 256; i++) begin
         if (!qv[i] || qkey[i] == hash) return i;
         if (qstamp[i] < qstamp[v]) v = i;
      end
      return v;
   endfunction

   // update the tables for an accepted request and queue its response
   function void note_request(logic [1:0] f, logic [31:0] id, logic [31:0] hash);
      usage_resp_type r;
      int w;
      int q;
      logic [31:0] age;
      logic [7:0] m;
      r = '{default: '0};
      case (f)
         wqult_pkg::FUNC_TICK: clk_now = clk_now + 1;
         wqult_pkg::FUNC_RECORD: begin
            w = lookup_word(id);
            if (w < 0) begin
               w = pick_word_slot();
               wv[w] = 1; wkey[w] = id; wuses[w] = 0;
            end
            if (wuses[w] != 8'd255) wuses[w] = wuses[w] + 1;
            wstamp[w] = clk_now;
            if (hash != 0) begin
               q = pick_query_slot(hash);
               if (!qv[q] || qkey[q] != hash || qword[q] != id) begin
                  qv[q] = 1; qkey[q] = hash; qword[q] = id; quses[q] = 0;
               end
               if (quses[q] != 8'd255) quses[q] = quses[q] + 1;
               qstamp[q] = clk_now;
            end
         end
         wqult_pkg::FUNC_REMOVE: begin
            for (int i = 0; i < 256; i++)
               if (wv[i] && wkey[i] == id) begin
                  wv[i] = 0; wkey[i] = 0; wuses[i] = 0; wstamp[i] = 0;
                  r.removed = 1;
               end
            for (int i = 0; i < 256; i++)
               if (qv[i] && qword[i] == id && (hash == 0 || qkey[i] == hash)) begin
                  qv[i] = 0; qkey[i] = 0; qword[i] = 0; quses[i] = 0; qstamp[i] = 0;
                  r.removed = 1;
               end
         end
         default: begin
            w = lookup_word(id);
            if (w >= 0) begin
               age = clk_now - wstamp[w];
               r.use_count = wuses[w];
               m = (wuses[w] < wcap) ? wuses[w] : wcap;
               r.freq_bonus = 24'(m) * 24'(wstep);
               if (age < {16'd0, rwin})
                  r.recency_bonus = 32'(({16'd0, rwin} - age) * rstep);
            end
            if (hash != 0) begin
               for (int i = 0; i < 256; i++)
                  if (qv[i] && qkey[i] == hash && qword[i] == id) begin
                     m = (quses[i] < qcap) ? quses[i] : qcap;
                     r.query_bonus = 24'(m) * 24'(qstep);
                     break;
                  end
               for (int i = 0; i < 256; i++)
                  if (qv[i] && qkey[i] == hash && qword[i] == id &&
                      32'(clk_now - qstamp[i]) <= pwin) begin
                     r.preference_rank = wqult_pkg::RANK_PREFERRED;
                     break;
                  end
            end
         end
      endcase
      pending.push_back(r);
   endfunction

   // compare one strobed response with the oldest expectation
   function void check_result(usage_resp_type got);
      usage_resp_type e;
      if (pending.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.removed !== e.removed) begin
         $error("removed expected %0d got %0d", e.removed, got.removed); errors++;
      end
      if (got.use_count !== e.use_count) begin
         $error("use_count expected %0d got %0d", e.use_count, got.use_count); errors++;
      end
      if (got.freq_bonus !== e.freq_bonus) begin
         $error("freq_bonus expected %0d got %0d", e.freq_bonus, got.freq_bonus); errors++;
      end
      if (got.recency_bonus !== e.recency_bonus) begin
         $error("recency_bonus expected %0d got %0d", e.recency_bonus, got.recency_bonus);
         errors++;
      end
      if (got.query_bonus !== e.query_bonus) begin
         $error("query_bonus expected %0d got %0d", e.query_bonus, got.query_bonus); errors++;
      end
      if (got.preference_rank !== e.preference_rank) begin
         $error("preference_rank expected %0d got %0d", e.preference_rank,
                got.preference_rank);
         errors++;
      end
   endfunction
endclass

module word_query_usage_learning_table_core_tb;
   import wqult_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_func;
   logic [31:0]            req_word_id;
   logic [31:0]            req_qhash;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   rsp_valid;
   logic                   rsp_removed;
   logic [7:0]             rsp_use_count;
   logic [23:0]            rsp_freq_bonus;
   logic [31:0]            rsp_recency_bonus;
   logic [23:0]            rsp_query_bonus;
   logic [1:0]             rsp_preference_rank;

   usage_scoreboard sb;
   int idle_pct;
   int quiet_cycles;
   logic [31:0] word_pool[8];
   logic [31:0] hash_pool[4];

   word_query_usage_learning_table_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_word_id(req_word_id), .req_qhash(req_qhash),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_removed(rsp_removed), .rsp_use_count(rsp_use_count),
      .rsp_freq_bonus(rsp_freq_bonus), .rsp_recency_bonus(rsp_recency_bonus),
      .rsp_query_bonus(rsp_query_bonus), .rsp_preference_rank(rsp_preference_rank)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // check every strobed response
   always @(posedge clock) begin
      usage_resp_type got;
      if (!reset && rsp_valid) begin
         got.removed = rsp_removed;
         got.use_count = rsp_use_count;
         got.freq_bonus = rsp_freq_bonus;
         got.recency_bonus = rsp_recency_bonus;
         got.query_bonus = rsp_query_bonus;
         got.preference_rank = rsp_preference_rank;
         sb.check_result(got);
      end
   end

   // watchdog: cycles with neither a request nor a response accepted
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("word_query_usage_learning_table_core_tb NOT OK");
            $finish;
         end
      end
   end

   // present one request and hold it until accepted; optional gap afterwards
   task automatic send_request(logic [1:0] f, logic [31:0] id, logic [31:0] hash);
      req_func <= f;
      req_word_id <= id;
      req_qhash <= hash;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(f, id, hash);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // drain outstanding requests, then load all registers
   task automatic load_config(logic [31:0] vals[7]);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data <= vals[i];
         sb.write_reg(CSR_INDEX_W'(i), vals[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [1:0] pick_func(int tick_w, int rec_w, int rem_w);
      int r;
      r = $urandom_range(99);
      if (r < tick_w) return FUNC_TICK;
      if (r < tick_w + rec_w) return FUNC_RECORD;
      if (r < tick_w + rec_w + rem_w) return FUNC_REMOVE;
      return FUNC_SCORE;
   endfunction

   function automatic logic [31:0] pick_hash();
      int r;
      r = $urandom_range(99);
      if (r < 25) return 32'd0;
      if (r < 80) return hash_pool[$urandom_range(3)];
      return $urandom;
   endfunction

   // mixed random traffic over a small pool of words
   task automatic run_mixed(int n);
      logic [31:0] id;
      for (int k = 0; k < n; k++) begin
         id = ($urandom_range(99) < 75) ? word_pool[$urandom_range(7)] : $urandom;
         send_request(pick_func(30, 35, 8), id, pick_hash());
      end
   endtask

   initial begin
      logic [31:0] cfg[7];
      logic [31:0] id;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_TICK;
      req_word_id = '0;
      req_qhash = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 0;
      quiet_cycles = 0;
      word_pool = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'h5555_AAAA,
                    32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_00FF};
      hash_pool = '{32'hFFFF_FFFF, 32'd1, 32'hA5A5_5A5A, 32'h7FFF_FFFF};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, all operations, pairing restart, removes
      send_request(FUNC_SCORE, 32'd0, 32'd0);
      send_request(FUNC_RECORD, 32'd0, 32'd0);
      send_request(FUNC_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_SCORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_SCORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_SCORE, 32'hFFFF_FFFF, 32'd0);
      send_request(FUNC_RECORD, 32'd7, 32'hFFFF_FFFF);
      send_request(FUNC_SCORE, 32'd7, 32'hFFFF_FFFF);
      send_request(FUNC_SCORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_RECORD, 32'hFFFF_FFFF, 32'd1);
      send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 32'd1);
      send_request(FUNC_SCORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_REMOVE, 32'd7, 32'd0);
      send_request(FUNC_REMOVE, 32'd7, 32'd0);
      send_request(FUNC_SCORE, 32'd7, 32'hFFFF_FFFF);
      send_request(FUNC_SCORE, 32'd0, 32'd0);
      send_request(FUNC_REMOVE, 32'd0, 32'hFFFF_FFFF);

      // extremes: every register at its maximum
      cfg = '{32'hFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFF, 32'hFFFF, 32'hFFFF_FFFF};
      load_config(cfg);
      idle_pct = 60;
      run_mixed(90);

      // saturate counts on one word and one pairing
      idle_pct = 0;
      for (int k = 0; k < 280; k++) begin
         id = ($urandom_range(99) < 90) ? word_pool[1] : word_pool[$urandom_range(7)];
         send_request(pick_func(4, 88, 2), id,
                      ($urandom_range(99) < 85) ? hash_pool[0] : pick_hash());
      end

      // all zero registers
      cfg = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      load_config(cfg);
      idle_pct = 19;
      run_mixed(60);

      // fill both tables past capacity so replacement kicks in
      cfg = '{32'd16, 32'd8, 32'd64, 32'd4, 32'd16, 32'd16, 32'd32};
      load_config(cfg);
      idle_pct = 0;
      for (int k = 0; k < 300; k++) begin
         id = ($urandom_range(99) < 85) ? $urandom : word_pool[$urandom_range(7)];
         send_request(pick_func(15, 75, 2), id,
                      ($urandom_range(99) < 80) ? $urandom : pick_hash());
      end

      // random registers
      for (int i = 0; i < 7; i++) cfg[i] = $urandom;
      cfg[0] = $urandom_range(0, 20);
      cfg[2] = $urandom_range(1, 300);
      cfg[6] = $urandom_range(0, 60);
      load_config(cfg);
      idle_pct = 60;
      run_mixed(70);

      // wait for every response, then let the block settle
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("word_query_usage_learning_table_core_tb OK");
      end else begin
         $display("word_query_usage_learning_table_core_tb NOT OK");
      end
      $finish;
   end
endmodule
